@@ rtl/ate_pkg.sv @@
// ----------------------------------------------------------------------------
// ate_pkg: shared types and constants of the array table engine
// Field widths, command and status codes, sequencer states and the result
// record of the shared compare unit.
// ----------------------------------------------------------------------------
package ate_pkg;

    // default table depth
    localparam int DEPTH_DEF = 16;

    // request and result field widths
    localparam int W_KIND = 3;
    localparam int W_VAL  = 32;
    localparam int W_POS  = 5;
    localparam int W_CNT  = 5;
    localparam int W_STAT = 2;

    // command codes
    typedef enum logic [W_KIND-1:0] {
        K_CLEAR  = 3'd0,
        K_APPEND = 3'd1,
        K_READ   = 3'd2,
        K_SEARCH = 3'd3,
        K_SORT   = 3'd4,
        K_INSERT = 3'd5,
        K_DELETE = 3'd6
    } t_kind;

    // result status codes
    typedef enum logic [W_STAT-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EMIT,
        S_RD_DATA,
        S_SR_DATA,
        S_SO_LDA,
        S_SO_CMP,
        S_SO_WRI,
        S_IN_RD,
        S_IN_WR,
        S_DL_GONE,
        S_DL_RD,
        S_DL_WR
    } t_state;

    // compare unit result
    typedef struct packed {
        logic gt;
        logic eq;
    } t_cmp;

endpackage

@@ rtl/ate_if.sv @@
// ----------------------------------------------------------------------------
// ate_if: request and result channels of the array table engine
// Valid/ready channels; an item moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------

// command request channel
interface ate_in_if;
    logic                                valid;
    logic                                ready;
    logic        [ate_pkg::W_KIND-1:0]   kind;
    logic signed [ate_pkg::W_VAL-1:0]    value;
    logic        [ate_pkg::W_POS-1:0]    position;

    modport source (output valid, output kind, output value, output position, input ready);
    modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

// result channel
interface ate_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ate_pkg::W_VAL-1:0]    element;
    logic                                found;
    logic        [ate_pkg::W_CNT-1:0]    count;
    logic        [ate_pkg::W_STAT-1:0]   status;
    logic                                last;

    modport source (output valid, output element, output found, output count,
                    output status, output last, input ready);
    modport sink   (input valid, input element, input found, input count,
                    input status, input last, output ready);
endinterface

@@ rtl/ate_ram.sv @@
// ----------------------------------------------------------------------------
// ate_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ate_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ate_cmp.sv @@
// ----------------------------------------------------------------------------
// ate_cmp: shared signed compare unit
// Serves the search (equality) and the exchange sort (signed greater than).
// ----------------------------------------------------------------------------
module ate_cmp (
    input  logic signed [ate_pkg::W_VAL-1:0] i_a,
    input  logic signed [ate_pkg::W_VAL-1:0] i_b,
    output ate_pkg::t_cmp                    o_res
);

    // one magnitude compare and one equality compare
    always_comb begin
        o_res.gt = (i_a > i_b);
        o_res.eq = (i_a == i_b);
    end

endmodule

@@ rtl/array_table_engine.sv @@
// ----------------------------------------------------------------------------
// array_table_engine: bounded table of signed words under a command sequencer
// Holds up to DEPTH words and a fill count; runs clear, append, read all,
// search, exchange sort, insert and delete, one command at a time.
// ----------------------------------------------------------------------------
// Usage
//   i_cmd carries one command request (kind, value, position); o_res carries
//   results (element, found, count, status, last). i_cmd.ready is high only
//   while the sequencer is idle; a command is taken, worked through the table
//   memory one entry per step, and its results are placed in an output
//   register, so the next request is taken while the last result still waits.
//   Search scans one entry per step, read all gives one result per entry held,
//   insert and delete move each shifted entry with a read and a write step, and
//   sort compares each pair of held entries once. A new request is taken the
//   cycle after the last result is registered. All steps are set by the single
//   table memory port pair and the one shared compare unit. Kind seven is
//   dropped with no result.
//   Reset empties the table (fill count zero) and drops any held result; no
//   memory clearing pass is run. When the receiver stalls the sequencer
//   holds in place, read all resumes where it stopped, nothing is lost.
// ----------------------------------------------------------------------------
module array_table_engine #(
    parameter int DEPTH = ate_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ate_in_if.sink    i_cmd,
    ate_out_if.source o_res
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int XW   = CW + 6;
    localparam int VW   = ate_pkg::W_VAL;
    localparam int CNTW = ate_pkg::W_CNT;

    ate_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_fill, n_fill;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_j, n_j;
    logic [VW-1:0]   r_a, n_a;

    // latched request
    logic [ate_pkg::W_KIND-1:0] r_kind;
    logic [VW-1:0]              r_val;
    logic [ate_pkg::W_POS-1:0]  r_pos;

    // pending single result
    logic [VW-1:0]     r_res_elem, n_res_elem;
    logic              r_res_found, n_res_found;
    ate_pkg::t_status  r_res_status, n_res_status;

    // output register
    logic              r_out_valid;
    logic [VW-1:0]     r_out_elem;
    logic              r_out_found;
    logic [CNTW-1:0]   r_out_count;
    ate_pkg::t_status  r_out_status;
    logic              r_out_last;

    logic              w_load;
    logic [VW-1:0]     w_ld_elem;
    logic              w_ld_found;
    ate_pkg::t_status  w_ld_status;
    logic              w_ld_last;
    logic              w_out_free;
    logic              w_accept;

    // memory ports
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [VW-1:0]     w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [VW-1:0]     w_rdata;

    // shared compare
    logic [VW-1:0]     w_cmp_a;
    ate_pkg::t_cmp     w_cmp;

    // position checks
    logic [XW-1:0]     w_pos_x;
    logic [XW-1:0]     w_fill_x;
    logic [CW-1:0]     w_pos_m1;
    logic              w_full;

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_pos_x    = XW'(r_pos);
    assign w_fill_x   = XW'(r_fill);
    assign w_pos_m1   = CW'(w_pos_x - XW'(1));
    assign w_full     = (r_fill == CW'(DEPTH));

    ate_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_cmp_a = (r_state == ate_pkg::S_SR_DATA) ? r_val : r_a;

    ate_cmp u_cmp (
        .i_a   (w_cmp_a),
        .i_b   (w_rdata),
        .o_res (w_cmp)
    );

    // state, fill count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ate_pkg::S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_i          <= n_i;
        r_j          <= n_j;
        r_a          <= n_a;
        r_res_elem   <= n_res_elem;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        if (w_accept) begin
            r_kind <= i_cmd.kind;
            r_val  <= i_cmd.value;
            r_pos  <= i_cmd.position;
        end
        if (w_load) begin
            r_out_elem   <= w_ld_elem;
            r_out_found  <= w_ld_found;
            r_out_count  <= CNTW'(r_fill);
            r_out_status <= w_ld_status;
            r_out_last   <= w_ld_last;
        end
    end

    // sequencer: next state, memory control and result loading
    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_i          = r_i;
        n_j          = r_j;
        n_a          = r_a;
        n_res_elem   = r_res_elem;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        w_we         = 1'b0;
        w_waddr      = r_i[AW-1:0];
        w_wdata      = r_a;
        w_raddr      = r_i[AW-1:0];
        w_load       = 1'b0;
        w_ld_elem    = r_res_elem;
        w_ld_found   = r_res_found;
        w_ld_status  = r_res_status;
        w_ld_last    = 1'b1;

        unique case (r_state)
            ate_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = ate_pkg::S_DECODE;
                end
            end

            ate_pkg::S_DECODE: begin
                n_res_elem   = '0;
                n_res_found  = 1'b0;
                n_res_status = ate_pkg::STAT_OK;
                n_state      = ate_pkg::S_EMIT;
                n_i          = '0;
                w_raddr      = '0;
                unique case (r_kind)
                    ate_pkg::K_CLEAR: begin
                        n_fill = '0;
                    end
                    ate_pkg::K_APPEND: begin
                        if (w_full) begin
                            n_res_status = ate_pkg::STAT_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = r_fill[AW-1:0];
                            w_wdata = r_val;
                            n_fill  = r_fill + CW'(1);
                        end
                    end
                    ate_pkg::K_READ: begin
                        if (r_fill == '0) begin
                            n_res_status = ate_pkg::STAT_BAD;
                        end else begin
                            n_state = ate_pkg::S_RD_DATA;
                        end
                    end
                    ate_pkg::K_SEARCH: begin
                        if (r_fill != '0) begin
                            n_state = ate_pkg::S_SR_DATA;
                        end
                    end
                    ate_pkg::K_SORT: begin
                        if (r_fill > CW'(1)) begin
                            n_j     = CW'(1);
                            n_state = ate_pkg::S_SO_LDA;
                        end
                    end
                    ate_pkg::K_INSERT: begin
                        if (w_full) begin
                            n_res_status = ate_pkg::STAT_FULL;
                        end else if (w_pos_x == '0 || w_pos_x > w_fill_x + XW'(1)) begin
                            n_res_status = ate_pkg::STAT_BAD;
                        end else begin
                            n_i     = r_fill;
                            n_state = ate_pkg::S_IN_RD;
                        end
                    end
                    ate_pkg::K_DELETE: begin
                        if (r_fill == '0 || w_pos_x == '0 || w_pos_x > w_fill_x) begin
                            n_res_status = ate_pkg::STAT_BAD;
                        end else begin
                            n_i     = w_pos_m1;
                            w_raddr = w_pos_m1[AW-1:0];
                            n_state = ate_pkg::S_DL_GONE;
                        end
                    end
                    default: begin
                        // unused code: no result
                        n_state = ate_pkg::S_IDLE;
                    end
                endcase
            end

            ate_pkg::S_EMIT: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ate_pkg::S_IDLE;
                end
            end

            // read all: one entry per result, address held while stalled
            ate_pkg::S_RD_DATA: begin
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_ld_elem   = w_rdata;
                    w_ld_found  = 1'b0;
                    w_ld_status = ate_pkg::STAT_OK;
                    w_ld_last   = ((r_i + CW'(1)) == r_fill);
                    w_raddr     = AW'(r_i + CW'(1));
                    n_i         = r_i + CW'(1);
                    if (w_ld_last) begin
                        n_state = ate_pkg::S_IDLE;
                    end
                end
            end

            // linear search, one entry per cycle
            ate_pkg::S_SR_DATA: begin
                if (w_cmp.eq) begin
                    n_res_found = 1'b1;
                    n_state     = ate_pkg::S_EMIT;
                end else if ((r_i + CW'(1)) == r_fill) begin
                    n_state = ate_pkg::S_EMIT;
                end else begin
                    w_raddr = AW'(r_i + CW'(1));
                    n_i     = r_i + CW'(1);
                end
            end

            // sort: hold the entry at i, fetch the first partner
            ate_pkg::S_SO_LDA: begin
                n_a     = w_rdata;
                w_raddr = r_j[AW-1:0];
                n_state = ate_pkg::S_SO_CMP;
            end

            // sort: compare held entry with entry j, exchange when greater
            ate_pkg::S_SO_CMP: begin
                if (w_cmp.gt) begin
                    w_we    = 1'b1;
                    w_waddr = r_j[AW-1:0];
                    w_wdata = r_a;
                    n_a     = w_rdata;
                end
                if ((r_j + CW'(1)) == r_fill) begin
                    n_state = ate_pkg::S_SO_WRI;
                end else begin
                    w_raddr = AW'(r_j + CW'(1));
                    n_j     = r_j + CW'(1);
                end
            end

            // sort: write back the smallest to i, then start the next pass or finish
            ate_pkg::S_SO_WRI: begin
                w_we    = 1'b1;
                w_waddr = r_i[AW-1:0];
                w_wdata = r_a;
                if ((r_i + CW'(2)) == r_fill) begin
                    n_state = ate_pkg::S_EMIT;
                end else begin
                    w_raddr = AW'(r_i + CW'(1));
                    n_i     = r_i + CW'(1);
                    n_j     = r_i + CW'(2);
                    n_state = ate_pkg::S_SO_LDA;
                end
            end

            // insert: shift entries up from the top, then place the word
            ate_pkg::S_IN_RD: begin
                if (r_i > w_pos_m1) begin
                    w_raddr = AW'(r_i - CW'(1));
                    n_state = ate_pkg::S_IN_WR;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_pos_m1[AW-1:0];
                    w_wdata = r_val;
                    n_fill  = r_fill + CW'(1);
                    n_state = ate_pkg::S_EMIT;
                end
            end

            ate_pkg::S_IN_WR: begin
                w_we    = 1'b1;
                w_waddr = r_i[AW-1:0];
                w_wdata = w_rdata;
                n_i     = r_i - CW'(1);
                n_state = ate_pkg::S_IN_RD;
            end

            // delete: keep the removed word, then shift entries down
            ate_pkg::S_DL_GONE: begin
                n_res_elem = w_rdata;
                n_state    = ate_pkg::S_DL_RD;
            end

            ate_pkg::S_DL_RD: begin
                if ((r_i + CW'(1)) < r_fill) begin
                    w_raddr = AW'(r_i + CW'(1));
                    n_state = ate_pkg::S_DL_WR;
                end else begin
                    n_fill  = r_fill - CW'(1);
                    n_state = ate_pkg::S_EMIT;
                end
            end

            ate_pkg::S_DL_WR: begin
                w_we    = 1'b1;
                w_waddr = r_i[AW-1:0];
                w_wdata = w_rdata;
                n_i     = r_i + CW'(1);
                n_state = ate_pkg::S_DL_RD;
            end

            default: begin
                n_state = ate_pkg::S_IDLE;
            end
        endcase
    end

    // channel outputs
    assign i_cmd.ready   = (r_state == ate_pkg::S_IDLE);
    assign o_res.valid   = r_out_valid;
    assign o_res.element = r_out_elem;
    assign o_res.found   = r_out_found;
    assign o_res.count   = r_out_count;
    assign o_res.status  = r_out_status;
    assign o_res.last    = r_out_last;

    // fill count never passes the table depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count beyond table depth");

    // one request at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_cmd.ready)
        else $error("request taken while busy");

    // sort partner index stays above i and inside the table
    a_sort_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ate_pkg::S_SO_CMP) |-> ((r_j > r_i) && (r_j < r_fill)))
        else $error("sort index out of range");

    // a found flag only on a good, final result
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |->
        ((r_out_status == ate_pkg::STAT_OK) && r_out_last))
        else $error("found flag on a bad result");

    // refused commands carry a zero element
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ate_pkg::STAT_OK)) |-> (r_out_elem == '0))
        else $error("element not zero on refused command");

endmodule
